@@ rtl/bgd_pkg.sv @@
// Shared types, codes and reset values for the button gesture decoder.
package bgd_pkg;

  localparam int TIME_BITS = 32;
  typedef logic [TIME_BITS-1:0] time_t;

  // Request codes
  localparam logic [1:0] REQ_EDGE = 2'd0;
  localparam logic [1:0] REQ_POLL = 2'd1;
  localparam logic [1:0] REQ_MODE = 2'd2;

  // Command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_PLAY  = 3'd2;
  localparam logic [2:0] CMD_PAUSE = 3'd3;
  localparam logic [2:0] CMD_NEXT  = 3'd4;

  // Player states
  localparam logic [1:0] PLAY_STOPPED = 2'd0;
  localparam logic [1:0] PLAY_PLAYING = 2'd1;
  localparam logic [1:0] PLAY_PAUSED  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DCW      = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;

  localparam logic [31:0] DCW_RESET      = 32'd250000;
  localparam logic [31:0] HOLD_RESET     = 32'd500000;
  localparam logic [7:0]  DEBOUNCE_RESET = 8'd12;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic       local_mode;
    logic [1:0] play_state;
    logic       button_down;
  } rsp_t;

  typedef struct packed {
    logic [31:0] double_click_window;
    logic [31:0] hold_time;
    logic [7:0]  debounce_time;
  } cfg_t;

endpackage

@@ rtl/bgd_cfg_regs.sv @@
// Configuration register file of the button gesture decoder.
module bgd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [31:0]   cfg_data,
  output bgd_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.double_click_window <= bgd_pkg::DCW_RESET;
      cfg.hold_time           <= bgd_pkg::HOLD_RESET;
      cfg.debounce_time       <= bgd_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bgd_pkg::REG_DCW:      cfg.double_click_window <= cfg_data;
        bgd_pkg::REG_HOLD:     cfg.hold_time           <= cfg_data;
        bgd_pkg::REG_DEBOUNCE: cfg.debounce_time       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/bgd_engine.sv @@
// Gesture state and single-pass update logic for one request beat.
module bgd_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  bgd_pkg::req_t req,
  input  bgd_pkg::cfg_t cfg,
  output bgd_pkg::rsp_t result
);

  logic                local_flag, local_flag_next;
  logic                pressed, pressed_next;
  logic                event_pending, event_pending_next;
  bgd_pkg::time_t      last_edge_time, last_edge_time_next;
  bgd_pkg::time_t      last_fall_time, last_fall_time_next;
  bgd_pkg::time_t      prior_fall_time, prior_fall_time_next;
  bgd_pkg::time_t      last_rise_time, last_rise_time_next;
  logic                debounce_active, debounce_active_next;
  bgd_pkg::time_t      debounce_until, debounce_until_next;
  bgd_pkg::time_t      dispatch_after, dispatch_after_next;
  logic [1:0]          player_state, player_state_next;
  logic [2:0]          pending_cmd, pending_cmd_next;
  logic [2:0]          issued_cmd, issued_cmd_next;
  logic                repeat_next, repeat_next_next;
  logic [2:0]          fired;

  bgd_pkg::time_t      t;
  bgd_pkg::time_t      dcw;
  bgd_pkg::time_t      hold_end;
  bgd_pkg::time_t      fall_gap;
  logic                edge_ok;
  logic                released;

  assign t        = bgd_pkg::time_t'(req.timestamp);
  assign dcw      = bgd_pkg::time_t'(cfg.double_click_window);
  assign hold_end = last_fall_time + bgd_pkg::time_t'(cfg.hold_time);
  assign fall_gap = last_fall_time - prior_fall_time;
  assign edge_ok  = !debounce_active || (debounce_until < t) ||
                    (last_edge_time == last_fall_time);
  assign released = (last_rise_time == last_edge_time);

  always_comb begin
    local_flag_next      = local_flag;
    pressed_next         = pressed;
    event_pending_next   = event_pending;
    last_edge_time_next  = last_edge_time;
    last_fall_time_next  = last_fall_time;
    prior_fall_time_next = prior_fall_time;
    last_rise_time_next  = last_rise_time;
    debounce_active_next = debounce_active;
    debounce_until_next  = debounce_until;
    dispatch_after_next  = dispatch_after;
    player_state_next    = player_state;
    pending_cmd_next     = pending_cmd;
    issued_cmd_next      = issued_cmd;
    repeat_next_next     = repeat_next;
    fired                = bgd_pkg::CMD_NONE;

    unique case (req.req_type)
      bgd_pkg::REQ_EDGE: begin
        if (local_flag && edge_ok) begin
          if (!pressed) begin
            prior_fall_time_next = last_fall_time;
            last_fall_time_next  = t;
            last_edge_time_next  = t;
            pressed_next         = 1'b1;
            event_pending_next   = 1'b1;
            dispatch_after_next  = t + dcw;
          end else begin
            last_rise_time_next = t;
            last_edge_time_next = t;
            pressed_next        = 1'b0;
          end
          debounce_active_next = 1'b1;
          debounce_until_next  = t + bgd_pkg::time_t'(cfg.debounce_time);
        end
      end
      bgd_pkg::REQ_POLL: begin
        if (debounce_active && (debounce_until < t)) begin
          debounce_active_next = 1'b0;
        end
        // Classify the pending press: hold wins, then double press, then click
        if (event_pending) begin
          priority if (pressed && (hold_end < t)) begin
            event_pending_next = 1'b0;
            player_state_next  = bgd_pkg::PLAY_STOPPED;
            pending_cmd_next   = bgd_pkg::CMD_STOP;
          end else if (pressed && (last_edge_time == last_fall_time) && (fall_gap <= dcw)) begin
            event_pending_next = 1'b0;
            repeat_next_next   = 1'b1;
            pending_cmd_next   = bgd_pkg::CMD_NEXT;
          end else if (((player_state == bgd_pkg::PLAY_STOPPED) ||
                        (player_state == bgd_pkg::PLAY_PAUSED)) && released) begin
            event_pending_next = 1'b0;
            player_state_next  = bgd_pkg::PLAY_PLAYING;
            pending_cmd_next   = bgd_pkg::CMD_PLAY;
          end else if ((player_state == bgd_pkg::PLAY_PLAYING) && released) begin
            event_pending_next = 1'b0;
            player_state_next  = bgd_pkg::PLAY_PAUSED;
            pending_cmd_next   = bgd_pkg::CMD_PAUSE;
          end else begin
          end
        end
        if ((dispatch_after < t) && ((issued_cmd != pending_cmd_next) || repeat_next_next)) begin
          repeat_next_next = 1'b0;
          issued_cmd_next  = pending_cmd_next;
          fired            = pending_cmd_next;
        end
      end
      bgd_pkg::REQ_MODE: begin
        local_flag_next = !local_flag;
      end
      default: ;
    endcase
  end

  assign result.action      = fired;
  assign result.local_mode  = local_flag_next;
  assign result.play_state  = player_state_next;
  assign result.button_down = pressed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_flag      <= 1'b0;
      pressed         <= 1'b0;
      event_pending   <= 1'b0;
      last_edge_time  <= '0;
      last_fall_time  <= '0;
      prior_fall_time <= '0;
      last_rise_time  <= '1;
      debounce_active <= 1'b0;
      debounce_until  <= '1;
      dispatch_after  <= '0;
      player_state    <= bgd_pkg::PLAY_STOPPED;
      pending_cmd     <= bgd_pkg::CMD_NONE;
      issued_cmd      <= bgd_pkg::CMD_NONE;
      repeat_next     <= 1'b0;
    end else if (step) begin
      local_flag      <= local_flag_next;
      pressed         <= pressed_next;
      event_pending   <= event_pending_next;
      last_edge_time  <= last_edge_time_next;
      last_fall_time  <= last_fall_time_next;
      prior_fall_time <= prior_fall_time_next;
      last_rise_time  <= last_rise_time_next;
      debounce_active <= debounce_active_next;
      debounce_until  <= debounce_until_next;
      dispatch_after  <= dispatch_after_next;
      player_state    <= player_state_next;
      pending_cmd     <= pending_cmd_next;
      issued_cmd      <= issued_cmd_next;
      repeat_next     <= repeat_next_next;
    end
  end

endmodule

@@ rtl/button_gesture_decoder_core.sv @@
// Top level of the button gesture decoder: input register, engine, result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   req     | in        | req_valid/req_ready  | req_type, timestamp
//   rsp     | out       | rsp_valid/rsp_ready  | action, local_mode, play_state,
//           |           |                      | button_down
//   cfg     | in        | cfg_we (no wait)     | cfg_addr, cfg_data
//
// One beat per cycle sustained while rsp_ready stays high; a result beat is
// offered from the result register once its request beat leaves the input register.
// The gesture state updates once per beat as it leaves the input register.
// Reset (rst, synchronous) empties both registers and loads the register
// defaults and the idle gesture state.
// A stalled result holds in the result register; the input register keeps
// taking one more beat behind it, then req_ready drops until rsp_ready returns.
module button_gesture_decoder_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bgd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bgd_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [31:0]   cfg_data
);

  bgd_pkg::cfg_t cfg;
  bgd_pkg::req_t stage_req;
  logic          stage_valid;
  logic          advance;
  bgd_pkg::rsp_t result;

  // Move the staged beat into the result register when that slot frees up.
  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;

  bgd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bgd_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .req    (stage_req),
    .cfg    (cfg),
    .result (result)
  );

  // Input register: capture a beat whenever the slot is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      stage_req <= req;
    end
  end

  // Result register: load on advance, drop once the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule
